[rtl/core/kbd_mb_pkg.sv]
`timescale 1ns / 1ps

package kbd_mb_pkg;

  // Key slots in one report and modifier events tracked
  localparam int KEY_SLOTS  = 6;
  localparam int MOD_COUNT  = 6;
  localparam int KEY_W      = 8;
  localparam int MOD_BITS_W = 7;

  // One scan step per new slot, per old slot and per modifier
  localparam int STEP_COUNT = 2 * KEY_SLOTS + MOD_COUNT;
  localparam int STEP_W     = $clog2(STEP_COUNT);

  // Input word: key slots then modifier bits, padded to whole bytes
  localparam int IN_BITS    = KEY_SLOTS * KEY_W + MOD_BITS_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Modifier bit positions in the report
  localparam int MB_LCTRL  = 0;
  localparam int MB_LSHIFT = 1;
  localparam int MB_LALT   = 2;
  localparam int MB_LWIN   = 3;
  localparam int MB_RCTRL  = 4;
  localparam int MB_RSHIFT = 5;
  localparam int MB_RALT   = 6;

  // Event kind codes
  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_MOD = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } kbd_state_t;

  typedef struct packed {
    key_t code;
    logic kind;
    logic released;
  } kbd_event_t;

endpackage

[rtl/core/keyboard_report_make_break_unit.sv]
`timescale 1ns / 1ps

// Channel  Dir  Word layout (lowest bit up)
// s_*      in   tdata: key_a..key_f (8 bits each), modifier_bits (7), pad to 56
// m_*      out  tdata: code (8); tuser: kind, released; tlast: last_event
//
// Each report is scanned slot by slot (six new slots, six old slots, six
// modifiers), then flushed; a new report is accepted only in idle. A single
// compare unit tests one slot against all six opposing slots per cycle unless
// a stalled output holds the scan on the next event found. Events leave through
// a one-word output register. Synchronous reset clears the previous report.
module keyboard_report_make_break_unit
  import kbd_mb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // key_a..key_f, modifier_bits, zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [KEY_W-1:0]      m_tdata,   // code
  output logic [1:0]            m_tuser,   // kind, released
  output logic                  m_tlast
);

  kbd_state_t state, state_next;

  logic [STEP_W-1:0]    step;
  key_t                 now_keys  [KEY_SLOTS];
  key_t                 prev_keys [KEY_SLOTS];
  logic [MOD_COUNT-1:0] mod_want;
  logic [MOD_COUNT-1:0] mod_held;
  logic [MOD_COUNT-1:0] mod_diff;
  logic [MOD_COUNT-1:0] mod_rel;

  logic       pend_valid;
  kbd_event_t pend_ev;

  // Scan control from the sequencer
  logic       accept;
  logic       out_free;
  logic       in_press, in_release;
  logic       hit;
  key_t       probe;
  logic       found;
  kbd_event_t cand_ev;
  logic       advance;
  logic       load_out;
  logic       out_last;
  logic       finish;
  logic [STEP_W-1:0] mod_idx;
  logic [MOD_COUNT-1:0] want_in;
  logic [MOD_BITS_W-1:0] mods_in;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign mods_in  = s_tdata[KEY_SLOTS*KEY_W +: MOD_BITS_W];

  // Modifier wants in event order: lalt, ralt, lshift, rshift, lwin, control
  assign want_in = {mods_in[MB_LCTRL] | mods_in[MB_RCTRL], mods_in[MB_LWIN],
                    mods_in[MB_RSHIFT], mods_in[MB_LSHIFT],
                    mods_in[MB_RALT], mods_in[MB_LALT]};

  // Shared compare unit: probe against the opposing report
  always_comb begin
    in_press   = (step < STEP_W'(KEY_SLOTS));
    in_release = !in_press && (step < STEP_W'(2 * KEY_SLOTS));
    probe      = in_press ? now_keys[0] : prev_keys[0];
    hit        = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (in_press) begin
        hit = hit | (prev_keys[j] == probe);
      end else begin
        hit = hit | (now_keys[j] == probe);
      end
    end
    mod_idx = step - STEP_W'(2 * KEY_SLOTS);
    if (in_press || in_release) begin
      found            = (probe != '0) && !hit;
      cand_ev.code     = probe;
      cand_ev.kind     = KIND_KEY;
      cand_ev.released = in_release;
    end else begin
      found            = mod_diff[0];
      cand_ev.code     = KEY_W'(mod_idx);
      cand_ev.kind     = KIND_MOD;
      cand_ev.released = mod_rel[0];
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    advance    = 1'b0;
    load_out   = 1'b0;
    out_last   = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        advance  = !found || !pend_valid || out_free;
        load_out = advance && found && pend_valid;
        if (advance && (step == STEP_W'(STEP_COUNT - 1))) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          load_out   = pend_valid;
          out_last   = 1'b1;
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Report capture, slot rotation and step counter
  always_ff @(posedge clk) begin
    if (accept) begin
      step <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        now_keys[i] <= s_tdata[i*KEY_W +: KEY_W];
      end
      mod_want <= want_in;
      mod_diff <= want_in ^ mod_held;
      mod_rel  <= ~want_in;
    end else if (advance) begin
      step <= step + STEP_W'(1);
      if (in_press) begin
        for (int i = 0; i < KEY_SLOTS - 1; i++) begin
          now_keys[i] <= now_keys[i+1];
        end
        now_keys[KEY_SLOTS-1] <= now_keys[0];
      end else if (!in_release) begin
        mod_diff <= mod_diff >> 1;
        mod_rel  <= mod_rel >> 1;
      end
    end
  end

  // Previous report and held modifiers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys[i] <= '0;
      end
      mod_held <= '0;
    end else if (finish) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys[i] <= now_keys[i];
      end
      mod_held <= mod_want;
    end else if (advance && in_release) begin
      for (int i = 0; i < KEY_SLOTS - 1; i++) begin
        prev_keys[i] <= prev_keys[i+1];
      end
      prev_keys[KEY_SLOTS-1] <= prev_keys[0];
    end
  end

  // Pending event: held back one so the final one can carry tlast
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (advance && found) begin
      pend_valid <= 1'b1;
    end else if (finish) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && found) begin
      pend_ev <= cand_ev;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= pend_ev.code;
      m_tuser <= {pend_ev.released, pend_ev.kind};
      m_tlast <= out_last;
    end
  end

endmodule
